@@ rtl/core/tecv_pkg.sv @@
// Shared widths, codes and port structs for the tranche effective curve block.
// Used by the divider, the loss store and the top level; depends on nothing.
`timescale 1ns / 1ps
package tecv_pkg;

    // Store geometry
    localparam int NUM_STRIKES = 16;
    localparam int NUM_DATES   = 64;
    localparam int SIDX_W      = $clog2(NUM_STRIKES);
    localparam int DIDX_W      = $clog2(NUM_DATES);
    localparam int MEM_AW      = SIDX_W + DIDX_W;

    // Value widths
    localparam int VAL_W   = 17;
    localparam int REC_W   = 16;
    localparam int NSU_W   = 5;
    localparam int NDU_W   = 7;
    localparam int CURVE_W = 18;
    localparam int BL_W    = 19;
    localparam int MUL_W   = 19;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int DIVN_W  = 52;
    localparam int DEN_W   = 32;

    localparam logic [VAL_W-1:0] ONE_Q16 = 17'h10000;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_RECOVERY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NSTRIKES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NDATES   = 2'd2;

    // Operation codes
    typedef enum logic [1:0] {
        OP_WR_STRIKE = 2'd0,
        OP_WR_LOSS   = 2'd1,
        OP_CONT      = 2'd2,
        OP_FEE       = 2'd3
    } opcode_t;

    // Error codes
    localparam logic [1:0] ERR_OK    = 2'd0;
    localparam logic [1:0] ERR_RANGE = 2'd1;
    localparam logic [1:0] ERR_ORDER = 2'd2;

    // How a strike lands on the grid
    typedef enum logic [1:0] {
        KIND_EXACT  = 2'd0,
        KIND_RAMP   = 2'd1,
        KIND_INTERP = 2'd2
    } kind_t;

    // Divider request and response
    typedef struct packed {
        logic                     start;
        logic signed [DIVN_W-1:0] dividend;
        logic [DEN_W-1:0]         divisor;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DIVN_W-1:0] quotient;
    } div_rsp_t;

endpackage

@@ rtl/core/tecv_div.sv @@
// Iterative signed-by-unsigned divider, one quotient bit per cycle, truncating.
// Depends on tecv_pkg for widths and the request and response structs.
`timescale 1ns / 1ps
module tecv_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  tecv_pkg::div_req_t req,
    output tecv_pkg::div_rsp_t rsp
);
    localparam int CNT_W = $clog2(tecv_pkg::DIVN_W);

    logic                          busy_reg;
    logic                          done_reg;
    logic                          neg_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [tecv_pkg::DIVN_W-1:0]   num_reg;
    logic [tecv_pkg::DEN_W-1:0]    rem_reg;
    logic [tecv_pkg::DEN_W-1:0]    den_reg;
    logic [tecv_pkg::DEN_W:0]      rem_sh;
    logic                          qbit;
    logic [tecv_pkg::DEN_W-1:0]    rem_next;

    // One restoring step on the shifted remainder.
    always_comb begin
        rem_sh = {rem_reg, num_reg[tecv_pkg::DIVN_W-1]};
        qbit   = (rem_sh >= {1'b0, den_reg});
        if (qbit) begin
            rem_next = tecv_pkg::DEN_W'(rem_sh - {1'b0, den_reg});
        end else begin
            rem_next = rem_sh[tecv_pkg::DEN_W-1:0];
        end
    end

    // Sequencing of the bit steps.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(tecv_pkg::DIVN_W - 1);
                neg_reg  <= req.dividend[tecv_pkg::DIVN_W-1];
                num_reg  <= req.dividend[tecv_pkg::DIVN_W-1] ? -req.dividend : req.dividend;
                den_reg  <= req.divisor;
                rem_reg  <= '0;
            end else if (busy_reg) begin
                rem_reg <= rem_next;
                num_reg <= {num_reg[tecv_pkg::DIVN_W-2:0], qbit};
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -$signed(num_reg) : $signed(num_reg);

    // A new division never starts over one in flight.
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        req.start |-> !busy_reg) else $error("divider restarted while busy");

    // Completion is a single-cycle pulse.
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |=> !done_reg) else $error("divider done held too long");

endmodule

@@ rtl/core/tecv_mem.sv @@
// Base expected-loss table, strike-major, one write and one registered read port.
// Depends on tecv_pkg for the address and data widths.
`timescale 1ns / 1ps
module tecv_mem (
    input  logic                          aclk,
    input  logic                          we,
    input  logic [tecv_pkg::MEM_AW-1:0]   waddr,
    input  logic [tecv_pkg::VAL_W-1:0]    wdata,
    input  logic [tecv_pkg::MEM_AW-1:0]   raddr,
    output logic [tecv_pkg::VAL_W-1:0]    rdata_reg
);
    localparam int DEPTH = tecv_pkg::NUM_STRIKES * tecv_pkg::NUM_DATES;

    logic [tecv_pkg::VAL_W-1:0] mem [DEPTH];

    // Write and registered read.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

endmodule

@@ rtl/core/tranche_effective_curve_interp.sv @@
// A write is stored when it is accepted; a bad query goes from idle through the emit state
// into the output register. A good query first works its breakpoints (fee leg), then searches
// the grid once per strike, then per date reads the loss table for each strike and divides for
// each ramp or interpolated strike (a grid point needs no division), then the final quotient
// and hand-off; the 52-step divider is shared. One query is worked at a time; the input
// is not ready until its last item is in the output register.
// Reset sets control and configuration; grid and loss stores are undefined until written.
`timescale 1ns / 1ps
module tranche_effective_curve_interp (
    input  logic                               aclk,
    input  logic                               aresetn,
    // Input items
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // strike_index[3:0], date_index[9:4], write_value[26:10],
    // low_strike[43:27], high_strike[60:44]
    input  logic [63:0]                        s_tdata,
    // opcode[1:0]
    input  logic [1:0]                         s_tuser,
    // Result items
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_date_index[5:0], curve_value[23:6]
    output logic [23:0]                        m_tdata,
    // error_code[1:0]
    output logic [1:0]                         m_tuser,
    output logic                               m_tlast,
    // Configuration writes
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [tecv_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [tecv_pkg::CFG_DATA_W-1:0]    cfg_data
);
    localparam int SW = tecv_pkg::SIDX_W;
    localparam int DW = tecv_pkg::DIDX_W;
    localparam int VW = tecv_pkg::VAL_W;

    typedef enum logic [17:0] {
        S_IDLE     = 18'h00001,
        S_BP_MUL   = 18'h00002,
        S_BP_DIV   = 18'h00004,
        S_BP_WAIT  = 18'h00008,
        S_SR_LAST  = 18'h00010,
        S_SR_FIRST = 18'h00020,
        S_SR_SCAN  = 18'h00040,
        S_EV_ADDR  = 18'h00080,
        S_EV_LA    = 18'h00100,
        S_EV_LB    = 18'h00200,
        S_EV_DIV   = 18'h00400,
        S_EV_WAIT  = 18'h00800,
        S_CB_MUL1  = 18'h01000,
        S_CB_MUL2  = 18'h02000,
        S_CB_MUL3  = 18'h04000,
        S_CB_DIV   = 18'h08000,
        S_CB_WAIT  = 18'h10000,
        S_EMIT     = 18'h20000
    } state_t;

    state_t state_reg, state_next;

    // Input fields
    tecv_pkg::opcode_t in_op;
    logic [SW-1:0]     in_si;
    logic [DW-1:0]     in_di;
    logic [VW-1:0]     in_wv, in_lo, in_hi;
    logic [1:0]        in_err;
    logic              s_fire;

    assign in_op = tecv_pkg::opcode_t'(s_tuser);
    assign in_si = s_tdata[3:0];
    assign in_di = s_tdata[9:4];
    assign in_wv = s_tdata[26:10];
    assign in_lo = s_tdata[43:27];
    assign in_hi = s_tdata[60:44];

    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        if (in_lo > tecv_pkg::ONE_Q16 || in_hi > tecv_pkg::ONE_Q16) begin
            in_err = tecv_pkg::ERR_RANGE;
        end else if (in_lo >= in_hi) begin
            in_err = tecv_pkg::ERR_ORDER;
        end else begin
            in_err = tecv_pkg::ERR_OK;
        end
    end

    // Configuration registers and their saturated forms
    logic [tecv_pkg::REC_W-1:0] rec_reg;
    logic [tecv_pkg::NSU_W-1:0] nsu_reg, n_eff;
    logic [tecv_pkg::NDU_W-1:0] ndu_reg, nd_eff;
    logic [SW-1:0]              nlast;

    always_comb begin
        if (nsu_reg == '0) begin
            n_eff = tecv_pkg::NSU_W'(1);
        end else if (nsu_reg > tecv_pkg::NSU_W'(tecv_pkg::NUM_STRIKES)) begin
            n_eff = tecv_pkg::NSU_W'(tecv_pkg::NUM_STRIKES);
        end else begin
            n_eff = nsu_reg;
        end
        if (ndu_reg == '0) begin
            nd_eff = tecv_pkg::NDU_W'(1);
        end else if (ndu_reg > tecv_pkg::NDU_W'(tecv_pkg::NUM_DATES)) begin
            nd_eff = tecv_pkg::NDU_W'(tecv_pkg::NUM_DATES);
        end else begin
            nd_eff = ndu_reg;
        end
    end
    assign nlast = SW'(n_eff - 1'b1);

    // Query working registers
    logic                    fee_reg;
    logic [VW-1:0]           lo_reg, hi_reg;
    logic [DW-1:0]           t_reg;
    logic [1:0]              j_reg, nstr_last;
    logic [SW-1:0]           hs_reg;
    logic [VW-1:0]           prev_reg, la_reg;
    logic [VW-1:0]           sk_reg [4];
    tecv_pkg::kind_t         kind_reg [4];
    logic [SW-1:0]           h_reg [4];
    logic [VW-1:0]           mf_reg [4];
    logic [VW-1:0]           df_reg [4];
    logic signed [tecv_pkg::BL_W-1:0]   bl_reg [4];
    logic signed [tecv_pkg::PROD_W-1:0] acc_reg, p_reg;
    logic [DW-1:0]           res_date_reg;
    logic [tecv_pkg::CURVE_W-1:0] res_val_reg;
    logic [1:0]              res_err_reg;
    logic                    res_last_reg;
    logic                    m_tvalid_reg, m_tlast_reg;
    logic [23:0]             m_tdata_reg;
    logic [1:0]              m_tuser_reg;
    logic                    out_free;

    assign nstr_last = fee_reg ? 2'd3 : 2'd1;
    assign out_free  = !m_tvalid_reg || m_tready;

    // Strike grid, read at one address per cycle
    logic [VW-1:0] grid_mem [tecv_pkg::NUM_STRIKES];
    logic [SW-1:0] g_addr;
    logic [VW-1:0] g_rd, cur_s;
    logic          scan_found;

    always_comb begin
        unique case (state_reg)
            S_SR_LAST:  g_addr = nlast;
            S_SR_FIRST: g_addr = '0;
            default:    g_addr = hs_reg;
        endcase
    end
    assign g_rd       = grid_mem[g_addr];
    assign cur_s      = sk_reg[j_reg];
    assign scan_found = (g_rd >= cur_s) || (hs_reg == nlast);

    // Loss table
    logic                        mem_we;
    logic [tecv_pkg::MEM_AW-1:0] mem_raddr;
    logic [VW-1:0]               mem_rd;

    assign mem_we = s_fire && (in_op == tecv_pkg::OP_WR_LOSS);
    always_comb begin
        if (state_reg == S_EV_LA) begin
            mem_raddr = {SW'(h_reg[j_reg] - 1'b1), t_reg};
        end else begin
            mem_raddr = {h_reg[j_reg], t_reg};
        end
    end

    tecv_mem u_mem (
        .aclk      (aclk),
        .we        (mem_we),
        .waddr     ({in_si, in_di}),
        .wdata     (in_wv),
        .raddr     (mem_raddr),
        .rdata_reg (mem_rd)
    );

    // Shared multiplier with a registered product
    logic signed [tecv_pkg::MUL_W-1:0] mul_a, mul_b;
    logic signed [tecv_pkg::BL_W-1:0]  dl, db;
    logic [VW-1:0]                     om, width;

    assign dl    = bl_reg[0] - bl_reg[1];
    assign db    = bl_reg[2] - bl_reg[3];
    assign om    = tecv_pkg::ONE_Q16 - {1'b0, rec_reg};
    assign width = hi_reg - lo_reg;

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_BP_MUL: begin
                mul_a = $signed({2'b0, om});
                mul_b = $signed({2'b0, tecv_pkg::ONE_Q16 - ((j_reg == 2'd2) ? lo_reg : hi_reg)});
            end
            S_EV_LA: begin
                mul_a = $signed({2'b0, mem_rd});
                mul_b = $signed({2'b0, mf_reg[j_reg]});
            end
            S_EV_LB: begin
                mul_a = $signed({2'b0, la_reg}) - $signed({2'b0, mem_rd});
                mul_b = $signed({2'b0, mf_reg[j_reg]});
            end
            S_CB_MUL1: begin
                mul_a = dl;
                mul_b = $signed({2'b0, om});
            end
            S_CB_MUL2: begin
                mul_a = db;
                mul_b = $signed({3'b0, rec_reg});
            end
            S_CB_MUL3: begin
                mul_a = $signed({2'b0, om});
                mul_b = $signed({2'b0, width});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        p_reg <= mul_a * mul_b;
    end

    // Shared divider
    tecv_pkg::div_req_t div_req;
    tecv_pkg::div_rsp_t div_rsp;

    always_comb begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = '0;
        unique case (state_reg)
            S_BP_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = tecv_pkg::DIVN_W'(p_reg);
                div_req.divisor  = {16'b0, rec_reg};
            end
            S_EV_DIV: begin
                div_req.start    = 1'b1;
                div_req.dividend = tecv_pkg::DIVN_W'(p_reg);
                div_req.divisor  = {15'b0, df_reg[j_reg]};
            end
            S_CB_DIV: begin
                div_req.start = 1'b1;
                if (fee_reg) begin
                    div_req.dividend = $signed({acc_reg[35:0], 16'b0});
                    div_req.divisor  = p_reg[tecv_pkg::DEN_W-1:0];
                end else begin
                    div_req.dividend = $signed({{17{dl[tecv_pkg::BL_W-1]}}, dl, 16'b0});
                    div_req.divisor  = {15'b0, width};
                end
            end
            default: begin
                div_req.start = 1'b0;
            end
        endcase
    end

    tecv_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    // Quotient post-processing
    logic signed [52:0]            cv;
    logic [tecv_pkg::CURVE_W-1:0]  cv_sat;
    logic [VW-1:0]                 bp_cap;

    always_comb begin
        cv = $signed({36'd0, tecv_pkg::ONE_Q16}) - $signed({div_rsp.quotient[51], div_rsp.quotient});
        if (cv > 53'sd131071) begin
            cv_sat = 18'h1FFFF;
        end else if (cv < -53'sd131072) begin
            cv_sat = 18'h20000;
        end else begin
            cv_sat = cv[tecv_pkg::CURVE_W-1:0];
        end
        if ($unsigned(div_rsp.quotient) > 52'd65536) begin
            bp_cap = tecv_pkg::ONE_Q16;
        end else begin
            bp_cap = div_rsp.quotient[VW-1:0];
        end
    end

    // Sequencer
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_fire && (in_op == tecv_pkg::OP_CONT || in_op == tecv_pkg::OP_FEE)) begin
                    if (in_err != tecv_pkg::ERR_OK) begin
                        state_next = S_EMIT;
                    end else if (in_op == tecv_pkg::OP_FEE && rec_reg != '0) begin
                        state_next = S_BP_MUL;
                    end else begin
                        state_next = S_SR_LAST;
                    end
                end
            end
            S_BP_MUL: state_next = S_BP_DIV;
            S_BP_DIV: state_next = S_BP_WAIT;
            S_BP_WAIT: begin
                if (div_rsp.done) begin
                    state_next = (j_reg == 2'd3) ? S_SR_LAST : S_BP_MUL;
                end
            end
            S_SR_LAST: begin
                if (cur_s >= g_rd) begin
                    state_next = (j_reg == nstr_last) ? S_EV_ADDR : S_SR_LAST;
                end else begin
                    state_next = S_SR_FIRST;
                end
            end
            S_SR_FIRST: begin
                if (cur_s < g_rd) begin
                    state_next = (j_reg == nstr_last) ? S_EV_ADDR : S_SR_LAST;
                end else begin
                    state_next = S_SR_SCAN;
                end
            end
            S_SR_SCAN: begin
                if (scan_found) begin
                    state_next = (j_reg == nstr_last) ? S_EV_ADDR : S_SR_LAST;
                end
            end
            S_EV_ADDR: state_next = S_EV_LA;
            S_EV_LA: begin
                case (kind_reg[j_reg])
                    tecv_pkg::KIND_RAMP:   state_next = S_EV_DIV;
                    tecv_pkg::KIND_INTERP: state_next = S_EV_LB;
                    default: begin
                        if (j_reg != nstr_last) begin
                            state_next = S_EV_ADDR;
                        end else begin
                            state_next = fee_reg ? S_CB_MUL1 : S_CB_DIV;
                        end
                    end
                endcase
            end
            S_EV_LB:  state_next = S_EV_DIV;
            S_EV_DIV: state_next = S_EV_WAIT;
            S_EV_WAIT: begin
                if (div_rsp.done) begin
                    if (j_reg != nstr_last) begin
                        state_next = S_EV_ADDR;
                    end else begin
                        state_next = fee_reg ? S_CB_MUL1 : S_CB_DIV;
                    end
                end
            end
            S_CB_MUL1: state_next = S_CB_MUL2;
            S_CB_MUL2: state_next = S_CB_MUL3;
            S_CB_MUL3: state_next = S_CB_DIV;
            S_CB_DIV:  state_next = S_CB_WAIT;
            S_CB_WAIT: begin
                if (div_rsp.done) begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    state_next = res_last_reg ? S_IDLE : S_EV_ADDR;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // Control registers: state, configuration, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            rec_reg      <= '0;
            nsu_reg      <= tecv_pkg::NSU_W'(1);
            ndu_reg      <= tecv_pkg::NDU_W'(1);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    tecv_pkg::CFG_RECOVERY: rec_reg <= cfg_data;
                    tecv_pkg::CFG_NSTRIKES: nsu_reg <= cfg_data[tecv_pkg::NSU_W-1:0];
                    tecv_pkg::CFG_NDATES:   ndu_reg <= cfg_data[tecv_pkg::NDU_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (state_reg == S_EMIT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end
        end
    end

    // Grid writes
    always_ff @(posedge aclk) begin
        if (s_fire && in_op == tecv_pkg::OP_WR_STRIKE) begin
            grid_mem[in_si] <= in_wv;
        end
    end

    // Datapath registers, stepped by the sequencer
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            S_IDLE: begin
                lo_reg       <= in_lo;
                hi_reg       <= in_hi;
                sk_reg[0]    <= in_hi;
                sk_reg[1]    <= in_lo;
                fee_reg      <= (in_op == tecv_pkg::OP_FEE) && (rec_reg != '0);
                j_reg        <= ((in_op == tecv_pkg::OP_FEE) && (rec_reg != '0)) ? 2'd2 : 2'd0;
                t_reg        <= '0;
                res_date_reg <= '0;
                res_val_reg  <= '0;
                res_err_reg  <= in_err;
                res_last_reg <= 1'b1;
            end
            S_BP_WAIT: begin
                if (div_rsp.done) begin
                    sk_reg[j_reg] <= bp_cap;
                    j_reg         <= (j_reg == 2'd3) ? 2'd0 : 2'd3;
                end
            end
            S_SR_LAST: begin
                if (cur_s >= g_rd) begin
                    kind_reg[j_reg] <= tecv_pkg::KIND_EXACT;
                    h_reg[j_reg]    <= nlast;
                    j_reg           <= (j_reg == nstr_last) ? 2'd0 : j_reg + 1'b1;
                end
            end
            S_SR_FIRST: begin
                if (cur_s < g_rd) begin
                    kind_reg[j_reg] <= tecv_pkg::KIND_RAMP;
                    h_reg[j_reg]    <= '0;
                    mf_reg[j_reg]   <= cur_s;
                    df_reg[j_reg]   <= g_rd;
                    j_reg           <= (j_reg == nstr_last) ? 2'd0 : j_reg + 1'b1;
                end else begin
                    hs_reg <= '0;
                end
            end
            S_SR_SCAN: begin
                if (scan_found) begin
                    h_reg[j_reg] <= hs_reg;
                    if (g_rd == cur_s || hs_reg == '0 || g_rd <= prev_reg) begin
                        kind_reg[j_reg] <= tecv_pkg::KIND_EXACT;
                    end else begin
                        kind_reg[j_reg] <= tecv_pkg::KIND_INTERP;
                        mf_reg[j_reg]   <= g_rd - cur_s;
                        df_reg[j_reg]   <= g_rd - prev_reg;
                    end
                    j_reg <= (j_reg == nstr_last) ? 2'd0 : j_reg + 1'b1;
                end else begin
                    prev_reg <= g_rd;
                    hs_reg   <= hs_reg + 1'b1;
                end
            end
            S_EV_LA: begin
                la_reg <= mem_rd;
                if (kind_reg[j_reg] != tecv_pkg::KIND_RAMP &&
                    kind_reg[j_reg] != tecv_pkg::KIND_INTERP) begin
                    bl_reg[j_reg] <= $signed({2'b0, mem_rd});
                    j_reg         <= (j_reg == nstr_last) ? 2'd0 : j_reg + 1'b1;
                end
            end
            S_EV_WAIT: begin
                if (div_rsp.done) begin
                    if (kind_reg[j_reg] == tecv_pkg::KIND_RAMP) begin
                        bl_reg[j_reg] <= $signed(div_rsp.quotient[tecv_pkg::BL_W-1:0]);
                    end else begin
                        bl_reg[j_reg] <= $signed({2'b0, la_reg}) -
                                         $signed(div_rsp.quotient[tecv_pkg::BL_W-1:0]);
                    end
                    j_reg <= (j_reg == nstr_last) ? 2'd0 : j_reg + 1'b1;
                end
            end
            S_CB_MUL2: acc_reg <= p_reg;
            S_CB_MUL3: acc_reg <= acc_reg + p_reg;
            S_CB_WAIT: begin
                if (div_rsp.done) begin
                    res_date_reg <= t_reg;
                    res_val_reg  <= cv_sat;
                    res_err_reg  <= tecv_pkg::ERR_OK;
                    res_last_reg <= ({1'b0, t_reg} == tecv_pkg::NDU_W'(nd_eff - 1'b1));
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    m_tdata_reg <= {res_val_reg, res_date_reg};
                    m_tuser_reg <= res_err_reg;
                    m_tlast_reg <= res_last_reg;
                    if (!res_last_reg) begin
                        t_reg <= t_reg + 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    // An error item always closes its query.
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser != tecv_pkg::ERR_OK) |-> m_tlast)
        else $error("error item without last");

    // Handing over the final item returns the sequencer to idle.
    a_last_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EMIT) && out_free && res_last_reg |=> (state_reg == S_IDLE))
        else $error("sequencer did not return to idle after the last item");

    // Quotients arrive only while the sequencer waits for them.
    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        div_rsp.done |-> (state_reg == S_BP_WAIT || state_reg == S_EV_WAIT ||
                          state_reg == S_CB_WAIT))
        else $error("divider finished outside a wait state");

endmodule

@@ test/tb_tranche_effective_curve_interp.sv @@
// Self-checking testbench for tranche_effective_curve_interp: loads strike grids and loss
// tables, runs contingent and fee queries and predicts every curve point. Depends on tecv_pkg.
`timescale 1ns / 1ps
module tb_tranche_effective_curve_interp;
    import tecv_pkg::*;

    localparam int WATCHDOG_LIMIT = 40000;

    typedef struct {
        logic [5:0]  date;
        logic [17:0] curve;
        logic [1:0]  err;
        logic        last;
    } curve_pt_t;

    // Predicts curve points and checks them in order.
    class curve_scoreboard;
        longint      grid[NUM_STRIKES];
        longint      loss[NUM_STRIKES][NUM_DATES];
        longint      recovery;
        int          nsu_reg;
        int          ndu_reg;
        curve_pt_t   pending[$];
        int          mismatches;

        function void clear();
            foreach (grid[k]) grid[k] = 0;
            foreach (loss[k, t]) loss[k][t] = 0;
            recovery = 0;
            nsu_reg = 1;
            ndu_reg = 1;
            mismatches = 0;
        endfunction

        function int strikes_used();
            if (nsu_reg < 1) return 1;
            return (nsu_reg > NUM_STRIKES) ? NUM_STRIKES : nsu_reg;
        endfunction

        function int dates_used();
            if (ndu_reg < 1) return 1;
            return (ndu_reg > NUM_DATES) ? NUM_DATES : ndu_reg;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_RECOVERY: recovery = data;
                CFG_NSTRIKES: nsu_reg = data[4:0];
                CFG_NDATES:   ndu_reg = data[6:0];
                default: ;
            endcase
        endfunction

        // Base loss at strike s for date t over the first n grid points.
        function longint loss_at(longint s, int t, int n);
            int h;
            longint lh, ll, ds;
            h = 0;
            if (s >= grid[n-1]) return loss[n-1][t];
            if (s < grid[0]) return (loss[0][t] * s) / grid[0];
            while (h < n && grid[h] < s) h++;
            if (h >= n) h = n - 1;
            lh = loss[h][t];
            if (grid[h] == s || h == 0) return lh;
            ll = loss[h-1][t];
            ds = grid[h] - grid[h-1];
            if (ds <= 0) return lh;
            return lh - ((lh - ll) * (grid[h] - s)) / ds;
        endfunction

        function longint brk(longint k);
            longint v;
            v = ((65536 - recovery) * (65536 - k)) / recovery;
            return (v > 65536) ? 65536 : v;
        endfunction

        function void note_input(opcode_t op, int si, int di, longint wv, longint lo,
                                 longint hi);
            curve_pt_t pt;
            int n, nd;
            longint dl, db, om, num, den, v;
            if (op == OP_WR_STRIKE) begin
                grid[si] = wv;
                return;
            end
            if (op == OP_WR_LOSS) begin
                loss[si][di] = wv;
                return;
            end
            pt.date = 0;
            pt.curve = 0;
            pt.last = 1;
            pt.err = ERR_OK;
            if (lo > 65536 || hi > 65536) pt.err = ERR_RANGE;
            else if (lo >= hi) pt.err = ERR_ORDER;
            if (pt.err != ERR_OK) begin
                pending.push_back(pt);
                return;
            end
            n = strikes_used();
            nd = dates_used();
            for (int t = 0; t < nd; t++) begin
                dl = loss_at(hi, t, n) - loss_at(lo, t, n);
                if (op == OP_FEE && recovery != 0) begin
                    om = 65536 - recovery;
                    db = loss_at(brk(lo), t, n) - loss_at(brk(hi), t, n);
                    num = (dl * om + db * recovery) * 65536;
                    den = om * (hi - lo);
                end else begin
                    num = dl * 65536;
                    den = hi - lo;
                end
                v = 65536 - num / den;
                if (v > 131071) v = 131071;
                if (v < -131072) v = -131072;
                pt.date = t[5:0];
                pt.curve = v[17:0];
                pt.last = (t == nd - 1);
                pending.push_back(pt);
            end
        endfunction

        function void check_result(curve_pt_t got);
            curve_pt_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected curve point: date %0d curve %h err %0d last %0d",
                             got.date, got.curve, got.err, got.last);
                return;
            end
            want = pending.pop_front();
            if (got.date !== want.date || got.curve !== want.curve ||
                got.err !== want.err || got.last !== want.last) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("curve point mismatch: expected date %0d curve %h err %0d last %0d, got date %0d curve %h err %0d last %0d",
                             want.date, want.curve, want.err, want.last,
                             got.date, got.curve, got.err, got.last);
            end
        endfunction
    endclass

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [63:0]           s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;
    logic [1:0]            m_tuser;
    logic                  m_tlast;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    curve_scoreboard sb;
    bit  quiet;
    bit  hold_req;
    bit  grid_ok[NUM_STRIKES];
    bit  loss_ok[NUM_STRIKES][NUM_DATES];
    int  idle_cycles;

    tranche_effective_curve_interp i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // Result monitor and watchdog on the rising edge.
    always @(posedge aclk) begin
        curve_pt_t got;
        if (!aresetn) begin
            idle_cycles <= 0;
        end else begin
            if ((s_tvalid && s_tready) || (cfg_valid && cfg_ready) || (m_tvalid && m_tready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (m_tvalid && m_tready) begin
                got.date = m_tdata[5:0];
                got.curve = m_tdata[23:6];
                got.err = m_tuser;
                got.last = m_tlast;
                sb.check_result(got);
            end
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // Receiver: random stalls, one long hold-off on request, none in the quiet part.
    initial begin
        m_tready = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 0;
                repeat (600) @(negedge aclk);
                hold_req = 0;
            end else if (!quiet && $urandom_range(0, 4) == 0) begin
                m_tready = 0;
                repeat ($urandom_range(0, 10)) @(negedge aclk);
            end else begin
                m_tready = 1;
            end
        end
    end

    task automatic send_item(opcode_t op, int si, int di, longint wv, longint lo, longint hi);
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            s_tvalid = 0;
            repeat ($urandom_range(1, 11)) @(negedge aclk);
        end
        s_tuser = op;
        s_tdata = {3'b0, hi[16:0], lo[16:0], wv[16:0], di[5:0], si[3:0]};
        s_tvalid = 1;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(op, si, di, wv, lo, hi);
        if (op == OP_WR_STRIKE) grid_ok[si] = 1;
        if (op == OP_WR_LOSS) loss_ok[si][di] = 1;
    endtask

    // Sender pause until every expected curve point has come back.
    task automatic drain();
        @(negedge aclk);
        s_tvalid = 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int data);
        @(negedge aclk);
        cfg_index = idx;
        cfg_data = CFG_DATA_W'(data);
        cfg_valid = 1;
        do @(posedge aclk); while (!cfg_ready);
        sb.write_reg(idx, CFG_DATA_W'(data));
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    task automatic set_regs(int rec, int nsu, int ndu);
        drain();
        write_reg(CFG_RECOVERY, rec);
        write_reg(CFG_NSTRIKES, nsu);
        write_reg(CFG_NDATES, ndu);
    endtask

    // Queries only read grid and table entries that have been written.
    task automatic query(opcode_t op, longint lo, longint hi);
        int n, nd;
        n = sb.strikes_used();
        nd = sb.dates_used();
        for (int k = 0; k < n; k++) begin
            if (!grid_ok[k])
                send_item(OP_WR_STRIKE, k, $urandom_range(0, 63),
                          (k + 1) * 65536 / n - $urandom_range(0, 2000 / n), 0, 0);
            for (int t = 0; t < nd; t++)
                if (!loss_ok[k][t])
                    send_item(OP_WR_LOSS, k, t, $urandom_range(0, 65536), 0, 0);
        end
        send_item(op, $urandom_range(0, 15), $urandom_range(0, 63),
                  $urandom_range(0, 131071), lo, hi);
    endtask

    task automatic random_item();
        int sel;
        longint lo, hi;
        opcode_t op;
        sel = $urandom_range(0, 19);
        op = $urandom_range(0, 1) ? OP_FEE : OP_CONT;
        if (sel < 2) begin
            send_item(OP_WR_STRIKE, $urandom_range(0, 15), $urandom_range(0, 63),
                      $urandom_range(0, 131071), 0, 0);
        end else if (sel < 5) begin
            send_item(OP_WR_LOSS, $urandom_range(0, 15), $urandom_range(0, 63),
                      $urandom_range(0, 1) ? $urandom_range(0, 131071) :
                      $urandom_range(0, 65536), 0, 0);
        end else if (sel < 6) begin
            query(op, $urandom_range(0, 131071), $urandom_range(0, 131071));
        end else if (sel < 7) begin
            lo = $urandom_range(0, 65536);
            query(op, lo, $urandom_range(0, lo));
        end else begin
            lo = $urandom_range(0, 65535);
            hi = $urandom_range(lo + 1, 65536);
            // Land on grid points now and then.
            if ($urandom_range(0, 3) == 0 && sb.grid[0] < hi) lo = sb.grid[0];
            if ($urandom_range(0, 3) == 0 && sb.grid[sb.strikes_used() - 1] > lo &&
                sb.grid[sb.strikes_used() - 1] <= 65536)
                hi = sb.grid[sb.strikes_used() - 1];
            query(op, lo, hi);
        end
    endtask

    initial begin
        int recs[8]  = '{16384, 0, 40000, 65535, 1, 12345, 50000, 20000};
        int nsus[8]  = '{16, 1, 3, 0, 31, 8, 2, 5};
        int ndus[8]  = '{2, 64, 1, 0, 4, 5, 8, 3};
        int counts[8] = '{48, 5, 48, 28, 38, 48, 38, 52};
        sb = new();
        sb.clear();
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = 0;
        s_tuser = OP_WR_STRIKE;
        cfg_valid = 0;
        cfg_index = CFG_RECOVERY;
        cfg_data = 0;
        quiet = 0;
        hold_req = 0;
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed: ordered four-point grid, three dates, zero recovery.
        set_regs(0, 4, 3);
        send_item(OP_WR_STRIKE, 0, 0, 8192, 0, 0);
        send_item(OP_WR_STRIKE, 1, 63, 16384, 0, 0);
        send_item(OP_WR_STRIKE, 2, 0, 32768, 0, 0);
        send_item(OP_WR_STRIKE, 3, 0, 65536, 0, 0);
        query(OP_CONT, 0, 65536);
        query(OP_CONT, 16384, 32768);
        query(OP_CONT, 4000, 20000);
        query(OP_FEE, 1000, 65536);
        query(OP_CONT, 65537, 131071);
        query(OP_CONT, 0, 131071);
        query(OP_FEE, 30000, 30000);
        query(OP_CONT, 40000, 20000);
        set_regs(32768, 4, 3);
        query(OP_FEE, 8192, 40000);
        query(OP_FEE, 0, 65536);
        set_regs(65535, 4, 3);
        query(OP_FEE, 100, 60000);
        set_regs(1, 4, 3);
        query(OP_FEE, 0, 1);
        // Unordered grid.
        send_item(OP_WR_STRIKE, 1, 0, 50000, 0, 0);
        query(OP_CONT, 20000, 45000);

        for (int p = 0; p < 8; p++) begin
            set_regs(recs[p], nsus[p], ndus[p]);
            if (p == 7) quiet = 1;
            for (int i = 0; i < counts[p]; i++) begin
                if (p == 0 && i == 20) hold_req = 1;
                random_item();
            end
        end

        drain();
        repeat (100) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/tecv_pkg.sv
rtl/core/tecv_div.sv
rtl/core/tecv_mem.sv
rtl/core/tranche_effective_curve_interp.sv
test/tb_tranche_effective_curve_interp.sv
